FILE: hw/rtl/kth_permutation_unrank_unit_assert.svh
// Assertion macros for the permutation unranking unit.
// Used by the port checker; depends on nothing else.
`ifndef KTH_PERMUTATION_UNRANK_UNIT_ASSERT_SVH
`define KTH_PERMUTATION_UNRANK_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KPU_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KPU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after reset is seen.
`define KPU_ASSERT_AFTER_RESET(label, clk, rst, cons, msg) \
   label: assert property (@(posedge clk) (rst) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/kpu_pkg.sv
// Shared types, widths and the factorial table of the permutation unranking unit.
// No dependencies.
`default_nettype none

package kpu_pkg;

   localparam int SIZE_W  = 4;
   localparam int RANK_W  = 19;
   localparam int DIGIT_W = 4;
   localparam int FACT_W  = 32;

   typedef struct packed {
      logic [SIZE_W-1:0] size_n;
      logic [RANK_W-1:0] rank_k;
   } req_payload_type;

   typedef struct packed {
      logic [DIGIT_W-1:0] digit;
      logic               last;
      logic               bad_rank;
   } rsp_payload_type;

   // Scalar part of a word as it moves down the digit pipeline.
   typedef struct packed {
      logic [SIZE_W-1:0] size_n;
      logic [RANK_W-1:0] rank;
      logic              bad_rank;
      logic [SIZE_W-1:0] position;
   } stage_meta_type;

   // Sizes above twelve are rejected whenever MAX_N is at most twelve, so their entry only has to be large.
   function automatic logic [FACT_W-1:0] factorial(input logic [SIZE_W-1:0] m);
      logic [FACT_W-1:0] f;
      unique case (m)
         4'd0:    f = 32'd1;
         4'd1:    f = 32'd1;
         4'd2:    f = 32'd2;
         4'd3:    f = 32'd6;
         4'd4:    f = 32'd24;
         4'd5:    f = 32'd120;
         4'd6:    f = 32'd720;
         4'd7:    f = 32'd5040;
         4'd8:    f = 32'd40320;
         4'd9:    f = 32'd362880;
         4'd10:   f = 32'd3628800;
         4'd11:   f = 32'd39916800;
         4'd12:   f = 32'd479001600;
         default: f = 32'hFFFF_FFFF;
      endcase
      return f;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/kpu_stream_if.sv
// Valid/ready stream channel carrying one payload word per handshake.
// Payload type is supplied by the instantiating module.
`default_nettype none

interface kpu_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/kpu_rank_check.sv
// Input stage: validates size and rank and forms the zero-based rank.
// Depends on kpu_pkg.
`default_nettype none

module kpu_rank_check #(
   parameter int MAX_N = 9
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire kpu_pkg::req_payload_type in_word,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output kpu_pkg::stage_meta_type       out_meta
);

   logic                         valid_ff;
   kpu_pkg::stage_meta_type      meta_ff;
   kpu_pkg::stage_meta_type      meta_in;
   logic [kpu_pkg::FACT_W-1:0]   size_fact;
   logic                         bad;

   always_comb begin
      size_fact = kpu_pkg::factorial(in_word.size_n);
      bad = (in_word.size_n == '0)
         || (in_word.size_n > kpu_pkg::SIZE_W'(MAX_N))
         || (in_word.rank_k == '0)
         || (kpu_pkg::FACT_W'(in_word.rank_k) > size_fact);
      meta_in.size_n   = in_word.size_n;
      meta_in.rank     = in_word.rank_k - kpu_pkg::RANK_W'(1);
      meta_in.bad_rank = bad;
      meta_in.position = '0;
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_meta  = meta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         meta_ff <= meta_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/kpu_digit_stage.sv
// One pipeline stage of the unranking: extracts the factorial-base digit of
// order ORDER from the rank and removes the chosen entry from the unused list.
// Depends on kpu_pkg.
`default_nettype none

module kpu_digit_stage #(
   parameter int MAX_N = 9,
   parameter int ORDER = 0
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     in_valid,
   output logic                                          in_ready,
   input  wire kpu_pkg::stage_meta_type                  in_meta,
   input  wire logic [MAX_N-1:0][kpu_pkg::DIGIT_W-1:0]   in_list,
   input  wire logic [MAX_N-1:0][kpu_pkg::DIGIT_W-1:0]   in_digits,
   output logic                                          out_valid,
   input  wire logic                                     out_ready,
   output kpu_pkg::stage_meta_type                       out_meta,
   output logic [MAX_N-1:0][kpu_pkg::DIGIT_W-1:0]        out_list,
   output logic [MAX_N-1:0][kpu_pkg::DIGIT_W-1:0]        out_digits
);

   localparam logic [kpu_pkg::FACT_W-1:0] ORDER_FACT =
      kpu_pkg::factorial(kpu_pkg::SIZE_W'(ORDER));

   logic                                      valid_ff;
   kpu_pkg::stage_meta_type                   meta_ff;
   kpu_pkg::stage_meta_type                   meta_in;
   logic [MAX_N-1:0][kpu_pkg::DIGIT_W-1:0]    list_ff;
   logic [MAX_N-1:0][kpu_pkg::DIGIT_W-1:0]    list_in;
   logic [MAX_N-1:0][kpu_pkg::DIGIT_W-1:0]    digits_ff;
   logic [MAX_N-1:0][kpu_pkg::DIGIT_W-1:0]    digits_in;
   logic                                      active;
   logic [kpu_pkg::SIZE_W-1:0]                quot;
   logic [kpu_pkg::RANK_W-1:0]                drop;
   logic [kpu_pkg::DIGIT_W-1:0]               pick;

   always_comb begin
      // Only the last size_n stages place a digit; earlier ones pass the word on.
      active = !in_meta.bad_rank && (kpu_pkg::SIZE_W'(ORDER) < in_meta.size_n);

      // The rank is below (ORDER+1)!, so the quotient is the largest multiple
      // of ORDER! that still fits; all multiples are compared at once.
      quot = '0;
      drop = '0;
      for (int m = 1; m <= ORDER; m++) begin
         if (kpu_pkg::FACT_W'(in_meta.rank) >= kpu_pkg::FACT_W'(m) * ORDER_FACT) begin
            quot = kpu_pkg::SIZE_W'(m);
            drop = kpu_pkg::RANK_W'(kpu_pkg::FACT_W'(m) * ORDER_FACT);
         end
      end

      pick = '0;
      for (int e = 0; e < MAX_N; e++) begin
         if (quot == kpu_pkg::SIZE_W'(e)) begin
            pick = in_list[e];
         end
      end

      list_in = in_list;
      for (int e = 0; e < MAX_N - 1; e++) begin
         if (active && (kpu_pkg::SIZE_W'(e) >= quot)) begin
            list_in[e] = in_list[e + 1];
         end
      end

      digits_in = in_digits;
      for (int e = 0; e < MAX_N; e++) begin
         if (active && (in_meta.position == kpu_pkg::SIZE_W'(e))) begin
            digits_in[e] = pick;
         end
      end

      meta_in = in_meta;
      if (active) begin
         meta_in.rank     = in_meta.rank - drop;
         meta_in.position = in_meta.position + kpu_pkg::SIZE_W'(1);
      end
   end

   assign in_ready   = !valid_ff || out_ready;
   assign out_valid  = valid_ff;
   assign out_meta   = meta_ff;
   assign out_list   = list_ff;
   assign out_digits = digits_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         meta_ff   <= meta_in;
         list_ff   <= list_in;
         digits_ff <= digits_in;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/kpu_serializer.sv
// Output stage: holds one finished permutation and sends it one digit per word.
// Depends on kpu_pkg.
`default_nettype none

module kpu_serializer #(
   parameter int MAX_N = 9
) (
   input  wire logic                                     clock,
   input  wire logic                                     reset,
   input  wire logic                                     in_valid,
   output logic                                          in_ready,
   input  wire kpu_pkg::stage_meta_type                  in_meta,
   input  wire logic [MAX_N-1:0][kpu_pkg::DIGIT_W-1:0]   in_digits,
   output logic                                          out_valid,
   input  wire logic                                     out_ready,
   output kpu_pkg::rsp_payload_type                      out_word
);

   logic                                      out_valid_ff;
   kpu_pkg::rsp_payload_type                  out_word_ff;
   logic [MAX_N-1:0][kpu_pkg::DIGIT_W-1:0]    digits_ff;
   logic [kpu_pkg::SIZE_W-1:0]                size_ff;
   logic [kpu_pkg::SIZE_W-1:0]                next_ff;
   kpu_pkg::rsp_payload_type                  first_word;
   kpu_pkg::rsp_payload_type                  next_word;
   logic                                      finishing;
   logic                                      advance;
   logic                                      load;

   always_comb begin
      if (in_meta.bad_rank) begin
         first_word.digit    = '0;
         first_word.last     = 1'b1;
         first_word.bad_rank = 1'b1;
      end else begin
         first_word.digit    = in_digits[0];
         first_word.last     = (in_meta.size_n == kpu_pkg::SIZE_W'(1));
         first_word.bad_rank = 1'b0;
      end

      next_word.digit = '0;
      for (int e = 0; e < MAX_N; e++) begin
         if (next_ff == kpu_pkg::SIZE_W'(e)) begin
            next_word.digit = digits_ff[e];
         end
      end
      next_word.last     = (next_ff + kpu_pkg::SIZE_W'(1) == size_ff);
      next_word.bad_rank = 1'b0;
   end

   // A new permutation may be taken in the cycle its predecessor's last word leaves.
   assign finishing = out_valid_ff && out_ready && out_word_ff.last;
   assign advance   = out_valid_ff && out_ready && !out_word_ff.last;
   assign in_ready  = !out_valid_ff || finishing;
   assign load      = in_valid && in_ready;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load) begin
         out_valid_ff <= 1'b1;
      end else if (finishing) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         digits_ff   <= in_digits;
         size_ff     <= in_meta.size_n;
         next_ff     <= kpu_pkg::SIZE_W'(1);
         out_word_ff <= first_word;
      end else if (advance) begin
         next_ff     <= next_ff + kpu_pkg::SIZE_W'(1);
         out_word_ff <= next_word;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/kth_permutation_unrank_unit.sv
// Path: an accepted request word is registered in the rank check, in each digit stage and
// in the serializer before its first result word is offered. Throughput: the digit pipeline
// takes one request per cycle while it is not stalled; the result port sends one word per
// cycle while ready is high, one word per digit (a lone word for a flagged request).
// Reset: synchronous, active high; it clears every stage valid bit, nothing else.
// Depends on kpu_pkg, kpu_stream_if, kpu_rank_check, kpu_digit_stage, kpu_serializer.
`default_nettype none

module kth_permutation_unrank_unit #(
   parameter int MAX_N = 9
) (
   input wire logic    clock,
   input wire logic    reset,
   kpu_stream_if.sink   req_chan,
   kpu_stream_if.source rsp_chan
);

   logic                                      stage_valid  [MAX_N+1];
   logic                                      stage_ready  [MAX_N+1];
   kpu_pkg::stage_meta_type                   stage_meta   [MAX_N+1];
   logic [MAX_N-1:0][kpu_pkg::DIGIT_W-1:0]    stage_list   [MAX_N+1];
   logic [MAX_N-1:0][kpu_pkg::DIGIT_W-1:0]    stage_digits [MAX_N+1];

   // The unused list starts as 1..MAX_N; entries past size_n are never picked.
   always_comb begin
      for (int e = 0; e < MAX_N; e++) begin
         stage_list[0][e] = kpu_pkg::DIGIT_W'(e + 1);
      end
      stage_digits[0] = '0;
   end

   kpu_rank_check #(.MAX_N(MAX_N)) u_check (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_chan.valid),
      .in_ready  (req_chan.ready),
      .in_word   (req_chan.payload),
      .out_valid (stage_valid[0]),
      .out_ready (stage_ready[0]),
      .out_meta  (stage_meta[0])
   );

   // Stage t extracts the digit of order MAX_N-1-t, highest order first.
   for (genvar t = 0; t < MAX_N; t++) begin : g_stage
      kpu_digit_stage #(.MAX_N(MAX_N), .ORDER(MAX_N - 1 - t)) u_stage (
         .clock      (clock),
         .reset      (reset),
         .in_valid   (stage_valid[t]),
         .in_ready   (stage_ready[t]),
         .in_meta    (stage_meta[t]),
         .in_list    (stage_list[t]),
         .in_digits  (stage_digits[t]),
         .out_valid  (stage_valid[t+1]),
         .out_ready  (stage_ready[t+1]),
         .out_meta   (stage_meta[t+1]),
         .out_list   (stage_list[t+1]),
         .out_digits (stage_digits[t+1])
      );
   end

   kpu_serializer #(.MAX_N(MAX_N)) u_serializer (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (stage_valid[MAX_N]),
      .in_ready  (stage_ready[MAX_N]),
      .in_meta   (stage_meta[MAX_N]),
      .in_digits (stage_digits[MAX_N]),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_word  (rsp_chan.payload)
   );

endmodule

`default_nettype wire

FILE: hw/rtl/kpu_checker.sv
// Port-level checks on the result channel of the permutation unranking unit,
// attached by bind. Depends on kpu_pkg and kth_permutation_unrank_unit_assert.svh.
`default_nettype none

`include "kth_permutation_unrank_unit_assert.svh"

module kpu_checker #(
   parameter int MAX_N = 9
) (
   input wire logic                     clock,
   input wire logic                     reset,
   input wire logic                     rsp_valid,
   input wire logic                     rsp_ready,
   input wire kpu_pkg::rsp_payload_type rsp_word
);

   `KPU_ASSERT_AFTER_RESET(a_idle_after_reset, clock, reset, !rsp_valid, "result valid after reset")

   `KPU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word), "stalled result word changed")

   `KPU_ASSERT_SAME(a_flag_form, clock, reset, rsp_valid && rsp_word.bad_rank, rsp_word.last && (rsp_word.digit == kpu_pkg::DIGIT_W'(0)), "flagged word is not a lone zero")

   `KPU_ASSERT_SAME(a_digit_range, clock, reset, rsp_valid && !rsp_word.bad_rank, (rsp_word.digit != kpu_pkg::DIGIT_W'(0)) && (rsp_word.digit <= kpu_pkg::DIGIT_W'(MAX_N)), "digit out of range")

endmodule

bind kth_permutation_unrank_unit kpu_checker #(.MAX_N(MAX_N)) u_kpu_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_word  (rsp_chan.payload)
);

`default_nettype wire

FILE: test/kpu_unrank_checker.sv
// Watches the request and result channels of the permutation unranking unit,
// predicts every digit word and compares it with what the block sends.
// Depends on kpu_pkg for the payload types.
module kpu_unrank_checker #(
   parameter int MAX_SIZE = 9
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_ready,
   input  kpu_pkg::req_payload_type req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_ready,
   input  kpu_pkg::rsp_payload_type rsp_payload,
   output int                       mismatch_count,
   output int                       digits_outstanding
);

   kpu_pkg::rsp_payload_type expected_digits[$];

   function automatic longint unsigned arrangements(input int unsigned m);
      longint unsigned f;
      f = 1;
      while (m > 0) begin
         f = f * m;
         m--;
      end
      return f;
   endfunction

   // Unranks one request into its digit words and appends them to the queue.
   function automatic void queue_permutation(input logic [3:0] size, input logic [18:0] rank);
      kpu_pkg::rsp_payload_type word;
      logic [3:0]               pool [MAX_SIZE];
      longint unsigned          remaining;
      longint unsigned          f;
      longint unsigned          q;
      int unsigned              count;
      int unsigned              idx;
      int unsigned              i;
      int unsigned              j;
      count = size;
      if (count == 0 || count > MAX_SIZE || rank == 0 || rank > arrangements(count)) begin
         word.digit    = '0;
         word.last     = 1'b1;
         word.bad_rank = 1'b1;
         expected_digits = {expected_digits, word};
      end else begin
         for (i = 0; i < count; i++) pool[i] = 4'(i + 1);
         remaining = rank - 1;
         for (i = 0; i < count; i++) begin
            f = arrangements(count - 1 - i);
            q = remaining / f;
            if (q >= count - i) q = count - i - 1;
            idx           = int'(q);
            word.digit    = pool[idx];
            word.last     = (i == count - 1);
            word.bad_rank = 1'b0;
            expected_digits = {expected_digits, word};
            // The chosen digit leaves the pool; later entries move down by one.
            for (j = idx; j + 1 < count - i; j++) pool[j] = pool[j + 1];
            remaining = remaining % f;
         end
      end
   endfunction

   always @(posedge clock) begin
      kpu_pkg::rsp_payload_type want;
      if (reset) begin
         mismatch_count     = 0;
         digits_outstanding = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_digits.size() == 0) begin
               $display("%0t: unexpected word: digit %0d last %0d bad_rank %0d", $time,
                        rsp_payload.digit, rsp_payload.last, rsp_payload.bad_rank);
               mismatch_count++;
            end else begin
               want = expected_digits.pop_front();
               if (rsp_payload.digit !== want.digit) begin
                  $display("%0t: digit mismatch: expected %0d, actual %0d", $time,
                           want.digit, rsp_payload.digit);
                  mismatch_count++;
               end
               if (rsp_payload.last !== want.last) begin
                  $display("%0t: last mismatch: expected %0d, actual %0d", $time,
                           want.last, rsp_payload.last);
                  mismatch_count++;
               end
               if (rsp_payload.bad_rank !== want.bad_rank) begin
                  $display("%0t: bad_rank mismatch: expected %0d, actual %0d", $time,
                           want.bad_rank, rsp_payload.bad_rank);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            queue_permutation(req_payload.size_n, req_payload.rank_k);
         digits_outstanding = expected_digits.size();
      end
   end

endmodule

FILE: test/tb_kth_permutation_unrank_unit.sv
// Top of the permutation unranking testbench: clock, reset, request stimulus and
// result back-pressure. Depends on kpu_pkg, kpu_stream_if, the unit and kpu_unrank_checker.
module tb_kth_permutation_unrank_unit;

   localparam int MAX_SIZE        = 9;
   localparam int RANDOM_REQUESTS = 460;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int IDLE_LIMIT      = 3000;
   localparam int DRAIN_CYCLES    = 2 * (MAX_SIZE + 1) + 4;

   typedef enum int {
      ALWAYS_READY,
      COIN_FLIP,
      MOSTLY_READY,
      EVERY_THIRD
   } stall_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_off_wanted = 1'b0;
   logic hold_off_done = 1'b0;
   int   burst_left = 0;
   int   idle_cycles = 0;
   int   mismatch_count;
   int   digits_outstanding;

   kpu_stream_if #(.payload_type(kpu_pkg::req_payload_type)) req_chan ();
   kpu_stream_if #(.payload_type(kpu_pkg::rsp_payload_type)) rsp_chan ();

   kth_permutation_unrank_unit #(
      .MAX_N(MAX_SIZE)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_chan.sink),
      .rsp_chan(rsp_chan.source)
   );

   kpu_unrank_checker #(
      .MAX_SIZE(MAX_SIZE)
   ) checker_unit (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_payload       (req_chan.payload),
      .rsp_valid         (rsp_chan.valid),
      .rsp_ready         (rsp_chan.ready),
      .rsp_payload       (rsp_chan.payload),
      .mismatch_count    (mismatch_count),
      .digits_outstanding(digits_outstanding)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
         $display("TB_ERROR");
         $finish;
      end
   end

   // Offers one request word, after a random gap when a burst has run out.
   task automatic send_request(input logic [3:0] size, input logic [18:0] rank);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 7) == 0) ? 60 : $urandom_range(1, 10);
         gap = ($urandom_range(0, 9) == 0) ? 25 : $urandom_range(0, 6);
         repeat (gap) begin
            @(negedge clock);
            req_chan.valid <= 1'b0;
         end
      end
      burst_left--;
      @(negedge clock);
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{size_n: size, rank_k: rank};
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // The result side stalls on its own schedule, with one long hold-off.
   initial begin
      stall_mode_type mode;
      int             mode_left;
      int             phase;
      rsp_chan.ready = 1'b0;
      mode = ALWAYS_READY;
      mode_left = 0;
      phase = 0;
      forever begin
         @(negedge clock);
         if (hold_off_wanted && !hold_off_done) begin
            rsp_chan.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_done = 1'b1;
         end else begin
            if (mode_left == 0) begin
               mode = stall_mode_type'($urandom_range(0, 3));
               mode_left = $urandom_range(30, 200);
            end
            mode_left--;
            phase++;
            case (mode)
               ALWAYS_READY: rsp_chan.ready <= 1'b1;
               COIN_FLIP:    rsp_chan.ready <= $urandom_range(0, 1);
               MOSTLY_READY: rsp_chan.ready <= ($urandom_range(0, 99) < 85);
               default:      rsp_chan.ready <= (phase % 3 != 0);
            endcase
         end
      end
   end

   initial begin
      int unsigned     pick;
      int unsigned     count;
      logic [3:0]      size;
      logic [18:0]     rank;
      longint unsigned total;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Extremes of both fields and every way a request can be rejected.
      send_request(4'd1, 19'd1);
      send_request(4'd2, 19'd1);
      send_request(4'd2, 19'd2);
      send_request(4'd3, 19'd4);
      send_request(4'd4, 19'd24);
      send_request(4'd5, 19'd61);
      send_request(4'd6, 19'd720);
      send_request(4'd7, 19'd5040);
      send_request(4'd8, 19'd40320);
      send_request(4'd9, 19'd1);
      send_request(4'd9, 19'd362880);
      send_request(4'd9, 19'd181440);
      send_request(4'd3, 19'd0);
      send_request(4'd3, 19'd7);
      send_request(4'd9, 19'd362881);
      send_request(4'd9, 19'h7FFFF);
      send_request(4'd0, 19'd1);
      send_request(4'd0, 19'd0);
      send_request(4'd10, 19'd1);
      send_request(4'd15, 19'h7FFFF);
      send_request(4'd1, 19'd2);
      send_request(4'd12, 19'd100);

      for (count = 0; count < RANDOM_REQUESTS; count++) begin
         if (count == 80) hold_off_wanted = 1'b1;
         pick  = $urandom_range(0, 99);
         size  = 4'($urandom_range(1, MAX_SIZE));
         total = kpu_pkg::factorial(size);
         if (pick < 80) begin
            rank = 19'($urandom_range(1, int'(total)));
         end else if (pick < 86) begin
            rank = ($urandom_range(0, 1) == 0) ? 19'd0 : 19'(total + $urandom_range(1, 3));
         end else if (pick < 93) begin
            rank = 19'($urandom_range(0, 19'h7FFFF));
         end else begin
            size = ($urandom_range(0, 2) == 0) ? 4'd0 : 4'($urandom_range(MAX_SIZE + 1, 15));
            rank = 19'($urandom_range(0, 19'h7FFFF));
         end
         send_request(size, rank);
      end
      @(negedge clock);
      req_chan.valid <= 1'b0;

      while (digits_outstanding != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

FILE: kth_permutation_unrank_unit.f
+incdir+hw/rtl
hw/rtl/kpu_pkg.sv
hw/rtl/kpu_stream_if.sv
hw/rtl/kpu_rank_check.sv
hw/rtl/kpu_digit_stage.sv
hw/rtl/kpu_serializer.sv
hw/rtl/kth_permutation_unrank_unit.sv
hw/rtl/kpu_checker.sv
test/kpu_unrank_checker.sv
test/tb_kth_permutation_unrank_unit.sv
